// ----- rtl/sfs_pkg.sv -----
// ---------------------------------------------------------------------------
// sfs_pkg: shared types and helpers for the symbol frequency sorter
// Holds the cell pair type, the cell command struct and the sort order.
// ---------------------------------------------------------------------------
package sfs_pkg;

   localparam int ALPHABET_SIZE = 64;
   localparam int COUNT_BITS    = 16;
   localparam int SYM_W         = 6;
   localparam int RUN_W         = 16;
   localparam int PASS_W        = $clog2(ALPHABET_SIZE);
   localparam int WIDE_W        = (COUNT_BITS > RUN_W) ? COUNT_BITS : RUN_W;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [RUN_W-1:0]      RUN_MAX   = '1;

   typedef struct packed {
      logic [SYM_W-1:0]      sym;
      logic [COUNT_BITS-1:0] count;
   } pair_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INIT,
      CELL_COUNT,
      CELL_SORT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic             phase;
      logic [SYM_W-1:0] symbol;
   } cell_ctrl_type;

   // True when a belongs ahead of b: higher count first, lower code on a tie.
   function automatic logic ranks_before(input pair_type a, input pair_type b);
      ranks_before = (a.count > b.count) || ((a.count == b.count) && (a.sym < b.sym));
   endfunction

   // Clamp a stored count to the width of the result port.
   function automatic logic [RUN_W-1:0] run_sat(input logic [COUNT_BITS-1:0] c);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(c);
      if (wide > WIDE_W'(RUN_MAX)) begin
         run_sat = RUN_MAX;
      end else begin
         run_sat = RUN_W'(wide);
      end
   endfunction

endpackage

// ----- rtl/sfs_cell.sv -----
// ---------------------------------------------------------------------------
// sfs_cell: one cell of the histogram and sorting chain
// Holds one symbol and its count; counts, compares and swaps with a
// neighbour, or shifts towards the head of the chain.
// ---------------------------------------------------------------------------
module sfs_cell import sfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic [SYM_W-1:0] cell_index,
   input  logic             has_left,
   input  logic             has_right,
   input  pair_type         left_pair,
   input  pair_type         right_pair,
   output pair_type         pair
);

   pair_type pair_ff;
   pair_type pair_in;
   pair_type home;

   assign home = '{sym: cell_index, count: '0};

   always_comb begin
      pair_in = pair_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            pair_in = pair_ff;
         end
         CELL_INIT: begin
            pair_in = home;
         end
         CELL_COUNT: begin
            if ((ctrl.symbol == pair_ff.sym) && (pair_ff.count != COUNT_MAX)) begin
               pair_in.count = pair_ff.count + 1'b1;
            end
         end
         CELL_SORT: begin
            // The lower cell of a pair keeps the better entry, the upper one the other.
            if (has_right && (cell_index[0] == ctrl.phase)) begin
               if (ranks_before(right_pair, pair_ff)) begin
                  pair_in = right_pair;
               end
            end else if (has_left && (cell_index[0] != ctrl.phase)) begin
               if (ranks_before(pair_ff, left_pair)) begin
                  pair_in = left_pair;
               end
            end
         end
         CELL_SHIFT: begin
            pair_in = has_right ? right_pair : home;
         end
         default: begin
            pair_in = pair_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= home;
      end else begin
         pair_ff <= pair_in;
      end
   end

   assign pair = pair_ff;

endmodule

// ----- rtl/symbol_frequency_sort_top.sv -----
// ---------------------------------------------------------------------------
// symbol_frequency_sort_top: histogram of a symbol string, emitted by count
// A chain of cells, one per symbol, counts the string and then sorts itself.
// ---------------------------------------------------------------------------
// Throughput: an ordinary symbol is taken whenever start is high, and busy
// stays low, so a new symbol may follow every cycle. The symbol flagged as the
// end of a string starts a sort of ALPHABET_SIZE odd-even passes through the
// cell chain, one pass per cycle; results then leave one per cycle, in the
// order they come out of the head cell, and a final step restores the chain.
// Busy stays high from the end of a string until the chain is restored. The
// receiver cannot stall. A synchronous reset clears all counts.
// ---------------------------------------------------------------------------
module symbol_frequency_sort_top import sfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_end_of_string,
   output logic             rsp_strobe,
   output logic [SYM_W-1:0] rsp_out_symbol,
   output logic [RUN_W-1:0] rsp_run_count,
   output logic             rsp_last_run
);

   typedef enum logic [1:0] {
      S_COUNT,
      S_SORT,
      S_EMIT
   } state_type;

   state_type            state_ff;
   logic [PASS_W-1:0]    pass_ff;
   logic                 accept;
   cell_ctrl_type        ctrl;
   pair_type             chain [ALPHABET_SIZE];

   // A request is taken only while counting.
   assign busy   = (state_ff != S_COUNT);
   assign accept = start && !busy;

   // The head cell carries the next result; once the chain is sorted every
   // nonzero count sits ahead of every zero count.
   assign rsp_strobe     = (state_ff == S_EMIT) && (chain[0].count != '0);
   assign rsp_out_symbol = chain[0].sym;
   assign rsp_run_count  = run_sat(chain[0].count);
   assign rsp_last_run   = (chain[1].count == '0);

   always_comb begin
      ctrl.op     = CELL_HOLD;
      ctrl.phase  = pass_ff[0];
      ctrl.symbol = req_symbol;
      unique case (state_ff)
         S_COUNT: begin
            if (accept) begin
               ctrl.op = CELL_COUNT;
            end
         end
         S_SORT: begin
            ctrl.op = CELL_SORT;
         end
         S_EMIT: begin
            // Shift out while results remain, then put every symbol back home.
            ctrl.op = rsp_strobe ? CELL_SHIFT : CELL_INIT;
         end
         default: begin
            ctrl.op = CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COUNT;
         pass_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_COUNT: begin
               pass_ff <= '0;
               if (accept && req_end_of_string) begin
                  state_ff <= S_SORT;
               end
            end
            S_SORT: begin
               pass_ff <= pass_ff + 1'b1;
               if (pass_ff == PASS_W'(ALPHABET_SIZE - 1)) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_strobe) begin
                  state_ff <= S_COUNT;
               end
            end
            default: begin
               state_ff <= S_COUNT;
            end
         endcase
      end
   end

   // The chain itself: cell i starts out owning symbol i.
   for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
      sfs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cell_index (SYM_W'(i)),
         .has_left   (i != 0),
         .has_right  (i != ALPHABET_SIZE - 1),
         .left_pair  (chain[(i == 0) ? 0 : i - 1]),
         .right_pair (chain[(i == ALPHABET_SIZE - 1) ? i : i + 1]),
         .pair       (chain[i])
      );
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the symbol frequency sorter
// Strings of symbol codes are fed through the request port, with random pauses
// between requests. A scoreboard keeps its own histogram and, whenever a
// string closes, works out the sorted list of (symbol, count) runs. Every run
// that the block emits is then checked against the oldest one still waiting.
// ---------------------------------------------------------------------------
module tb_top;
   import sfs_pkg::*;

   // Longer than the worst silent stretch: a full sort of
   // ALPHABET_SIZE passes plus the longest pause that the driver inserts.
   localparam int WATCHDOG_LIMIT = 1000;
   // Quiet time after the last expected run: a sort, a full emission and the
   // restoring step, with some margin.
   localparam int DRAIN_CYCLES   = 2 * ALPHABET_SIZE + 40;
   localparam int RANDOM_ITEMS   = 350;

   // One run of the sorted output as the block should present it.
   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic [RUN_W-1:0] count;
      logic             is_last;
   } run_t;

   // Histogram predictor and store of the runs that are still to come.
   class freq_sort_scoreboard;
      logic [COUNT_BITS-1:0] bin_count [ALPHABET_SIZE];
      run_t                  expected_runs [$];
      int                    mismatches;

      function new();
         foreach (bin_count[i]) bin_count[i] = '0;
         mismatches = 0;
      endfunction

      // An accepted request: count the symbol and, at the end of a string,
      // queue the sorted runs and clear the histogram.
      function void note_symbol(logic [SYM_W-1:0] sym, logic eos);
         bit                    taken [ALPHABET_SIZE];
         int                    best;
         int                    nonzero;
         logic [COUNT_BITS-1:0] best_count;
         longint unsigned       wide;
         run_t                  run;
         if (int'(sym) < ALPHABET_SIZE && bin_count[sym] != COUNT_MAX) begin
            bin_count[sym] = bin_count[sym] + 1'b1;
         end
         if (!eos) begin
            return;
         end
         nonzero = 0;
         foreach (bin_count[i]) begin
            taken[i] = 1'b0;
            if (bin_count[i] != '0) nonzero++;
         end
         for (int k = 0; k < nonzero; k++) begin
            best = 0;
            best_count = '0;
            // Strictly greater, so on a tie the lower code stays in front.
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
               if (!taken[i] && bin_count[i] > best_count) begin
                  best = i;
                  best_count = bin_count[i];
               end
            end
            taken[best] = 1'b1;
            wide = best_count;
            run.sym = SYM_W'(best);
            run.count = (wide > 64'(RUN_MAX)) ? RUN_MAX : RUN_W'(wide);
            run.is_last = (k == nonzero - 1);
            expected_runs.push_back(run);
         end
         foreach (bin_count[i]) bin_count[i] = '0;
      endfunction

      // A run seen on the result port, compared with the oldest expectation.
      function void check_run(logic [SYM_W-1:0] sym, logic [RUN_W-1:0] count,
                              logic is_last);
         run_t want;
         if (expected_runs.size() == 0) begin
            $error("unexpected run: out_symbol %0d run_count %0d last_run %0d",
                   sym, count, is_last);
            mismatches++;
            return;
         end
         want = expected_runs.pop_front();
         if (sym !== want.sym) begin
            $error("out_symbol: expected %0d, got %0d", want.sym, sym);
            mismatches++;
         end
         if (count !== want.count) begin
            $error("run_count: expected %0d, got %0d", want.count, count);
            mismatches++;
         end
         if (is_last !== want.is_last) begin
            $error("last_run: expected %0d, got %0d", want.is_last, is_last);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [SYM_W-1:0] req_symbol;
   logic             req_end_of_string;
   logic             rsp_strobe;
   logic [SYM_W-1:0] rsp_out_symbol;
   logic [RUN_W-1:0] rsp_run_count;
   logic             rsp_last_run;

   freq_sort_scoreboard sorted_runs = new();
   logic [SYM_W-1:0]    string_buf [$];
   int                  stall_cycles;

   symbol_frequency_sort_top uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_symbol        (req_symbol),
      .req_end_of_string (req_end_of_string),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_symbol    (rsp_out_symbol),
      .rsp_run_count     (rsp_run_count),
      .rsp_last_run      (rsp_last_run)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Everything is sampled at the rising edge, where the inputs driven at the
   // previous falling edge are stable and the block's outputs still hold the
   // values of the cycle that is ending.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sorted_runs.note_symbol(req_symbol, req_end_of_string);
         end
         if (rsp_strobe) begin
            sorted_runs.check_run(rsp_out_symbol, rsp_run_count, rsp_last_run);
         end
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles = 0;
         end else begin
            stall_cycles = stall_cycles + 1;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Drops start for the length of the pause; the payload ports carry junk meanwhile, which
   // the block must ignore.
   task automatic pause(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         req_symbol <= SYM_W'($urandom);
         req_end_of_string <= 1'($urandom);
      end
   endtask

   // Presents one request and holds it until the block takes it. Start stays
   // high across back-to-back requests, so it is only ever written once per
   // falling edge.
   task automatic send_symbol(logic [SYM_W-1:0] sym, logic eos);
      @(negedge clock);
      start <= 1'b1;
      req_symbol <= sym;
      req_end_of_string <= eos;
      do @(posedge clock); while (busy);
   endtask

   // Mostly no pause, now and then a short one, rarely a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Sends the buffered string, flagging its final symbol as the end.
   task automatic send_string(bit gappy);
      for (int i = 0; i < string_buf.size(); i++) begin
         if (gappy) pause(gap_length());
         send_symbol(string_buf[i], i == string_buf.size() - 1);
      end
      string_buf.delete();
   endtask

   initial begin
      int               sent;
      int               kind;
      int               len;
      int               pool_size;
      int               j;
      logic [SYM_W-1:0] pool [5];
      logic [SYM_W-1:0] held;
      logic [SYM_W-1:0] order [ALPHABET_SIZE];

      reset = 1'b1;
      start = 1'b0;
      req_symbol = '0;
      req_end_of_string = 1'b0;
      stall_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed strings. Lowest and highest code alone first.
      string_buf = '{6'd0};
      send_string(1'b0);
      string_buf = '{6'd63};
      send_string(1'b0);
      // Equal counts must come out lowest code first.
      string_buf = '{6'd9, 6'd5, 6'd9, 6'd5, 6'd2};
      send_string(1'b0);
      // Descending counts, with the end flag on the rarest symbol.
      string_buf = '{6'd40, 6'd17, 6'd17, 6'd40, 6'd17, 6'd1};
      send_string(1'b1);
      // A string straight after another checks that the histogram was cleared.
      string_buf = '{6'd63, 6'd0, 6'd63};
      send_string(1'b0);
      string_buf = '{6'd21, 6'd42};
      send_string(1'b1);

      // Random strings: mostly short ones from a small pool of symbols, so
      // that ties and larger counts are common; some fully random ones; and
      // now and then the whole alphabet in shuffled order, which yields the
      // largest possible emission.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            pool_size = $urandom_range(1, 5);
            foreach (pool[i]) pool[i] = SYM_W'($urandom);
            len = $urandom_range(1, 14);
            repeat (len) string_buf.push_back(pool[$urandom_range(0, pool_size - 1)]);
         end else if (kind < 95) begin
            len = $urandom_range(1, 30);
            repeat (len) string_buf.push_back(SYM_W'($urandom));
         end else begin
            foreach (order[i]) order[i] = SYM_W'(i);
            for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               held = order[i];
               order[i] = order[j];
               order[j] = held;
            end
            foreach (order[i]) string_buf.push_back(order[i]);
         end
         sent += string_buf.size();
         // About a third of the strings go in without any pause at all.
         send_string($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 3) == 0) pause(gap_length());
      end
      pause(1);

      while (sorted_runs.expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sorted_runs.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
